/* src/utf8sv_pkg.sv */
// ============================================================================
// utf8sv_pkg
// Shared types and constants of the UTF-8 stream decoder and validator.
// ============================================================================
package utf8sv_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_OVERLONG  = 3'd3,
        ST_SURROGATE = 3'd4,
        ST_ABOVE     = 3'd5,
        ST_TRUNC     = 3'd6
    } status_t;

    // Classification of a byte taken as the start of a sequence
    typedef enum logic [2:0] {
        LEAD_ASCII = 3'd0,
        LEAD_W2    = 3'd1,
        LEAD_W3    = 3'd2,
        LEAD_W4    = 3'd3,
        LEAD_BAD   = 3'd4
    } lead_kind_t;

    typedef struct packed {
        lead_kind_t  kind;
        logic [2:0]  width;
        logic [20:0] bits;
    } lead_t;

    // One result transaction as queued for the output
    typedef struct packed {
        logic [20:0] codepoint;
        logic [2:0]  seq_width;
        status_t     status;
        logic [31:0] cp_index;
        logic        end_of_text;
    } result_t;

    // Results produced by one input byte (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } batch_t;

    // Configuration register addressing
    localparam int unsigned CFG_ADDR_W       = 3;
    localparam logic        CFG_IDX_POLICY   = 1'b0;

    // Decode constants
    localparam logic [7:0]  MASK_LEAD2       = 8'hE0;
    localparam logic [7:0]  MATCH_LEAD2      = 8'hC0;
    localparam logic [7:0]  MASK_LEAD4       = 8'hF8;
    localparam logic [7:0]  MATCH_LEAD3      = 8'hE0;
    localparam logic [7:0]  LEAD4_MAX        = 8'hF4;
    localparam logic [20:0] MIN_CP_W2        = 21'h00080;
    localparam logic [20:0] MIN_CP_W3        = 21'h00800;
    localparam logic [20:0] MIN_CP_W4        = 21'h10000;
    localparam logic [20:0] SURR_LO          = 21'h0D800;
    localparam logic [20:0] SURR_HI          = 21'h0DFFF;
    localparam logic [20:0] MAX_CP           = 21'h10FFFF;
    localparam logic [31:0] INDEX_MAX        = 32'hFFFF_FFFF;

    // Classify a nonzero byte as a sequence lead
    function automatic lead_t decode_lead(input logic [7:0] b);
        lead_t l;
        l.kind  = LEAD_BAD;
        l.width = 3'd1;
        l.bits  = '0;
        if (b[7] == 1'b0) begin
            l.kind = LEAD_ASCII;
            l.bits = {13'd0, b};
        end else if ((b & MASK_LEAD2) == MATCH_LEAD2) begin
            l.kind  = LEAD_W2;
            l.width = 3'd2;
            l.bits  = {16'd0, b[4:0]};
        end else if (b[7:4] == MATCH_LEAD3[7:4]) begin
            l.kind  = LEAD_W3;
            l.width = 3'd3;
            l.bits  = {17'd0, b[3:0]};
        end else if ((b & MASK_LEAD4) == 8'hF0 && b <= LEAD4_MAX) begin
            l.kind  = LEAD_W4;
            l.width = 3'd4;
            l.bits  = {18'd0, b[2:0]};
        end
        return l;
    endfunction

endpackage

/* src/utf8sv_decode.sv */
// ============================================================================
// utf8sv_decode
// Sequence state and combinational decode of one byte into up to two results.
// ============================================================================
module utf8sv_decode
    import utf8sv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       error_policy,
    output batch_t     batch
);

    logic [2:0]  pend_width_reg, pend_width_next;
    logic [1:0]  bytes_rem_reg,  bytes_rem_next;
    logic [20:0] partial_reg,    partial_next;
    logic [31:0] valid_count_reg;
    logic        halted_reg,     halted_next;
    logic        count_clear;
    logic        ok_hit;

    lead_t       lead;
    result_t     lead_res;
    logic        lead_emit;
    logic        lead_ok;
    logic [20:0] cont_cp;
    logic [1:0]  rem_dec;
    status_t     fin_status;
    logic [2:0]  taken;
    result_t     blank;

    // Lead-byte view of the current byte
    always_comb begin
        lead      = decode_lead(data_byte);
        lead_emit = (lead.kind == LEAD_ASCII) || (lead.kind == LEAD_BAD);
        lead_ok   = (lead.kind == LEAD_ASCII);
        blank             = '0;
        blank.cp_index    = valid_count_reg;
        lead_res           = blank;
        lead_res.seq_width = 3'd1;
        lead_res.codepoint = lead_ok ? lead.bits : 21'd0;
        lead_res.status    = lead_ok ? ST_OK : ST_BAD_LEAD;
    end

    // Continuation view: assembled value and range checks
    always_comb begin
        cont_cp = {partial_reg[14:0], data_byte[5:0]};
        rem_dec = bytes_rem_reg - 2'd1;
        taken   = pend_width_reg - {1'b0, bytes_rem_reg};
        if ((pend_width_reg == 3'd2 && cont_cp < MIN_CP_W2) ||
            (pend_width_reg == 3'd3 && cont_cp < MIN_CP_W3) ||
            (pend_width_reg == 3'd4 && cont_cp < MIN_CP_W4)) begin
            fin_status = ST_OVERLONG;
        end else if (cont_cp >= SURR_LO && cont_cp <= SURR_HI) begin
            fin_status = ST_SURROGATE;
        end else if (cont_cp > MAX_CP) begin
            fin_status = ST_ABOVE;
        end else begin
            fin_status = ST_OK;
        end
    end

    // Next state and result batch
    always_comb begin
        batch           = '0;
        batch.slot0     = blank;
        batch.slot1     = blank;
        pend_width_next = pend_width_reg;
        bytes_rem_next  = bytes_rem_reg;
        partial_next    = partial_reg;
        halted_next     = halted_reg;
        count_clear     = 1'b0;
        ok_hit          = 1'b0;
        priority if (data_byte == 8'd0) begin
            // terminator: truncated report if open, then end marker
            if (pend_width_reg != 3'd0) begin
                batch.slot0.seq_width     = taken;
                batch.slot0.status        = ST_TRUNC;
                batch.slot1.end_of_text   = 1'b1;
                batch.count               = 2'd2;
            end else begin
                batch.slot0.end_of_text   = 1'b1;
                batch.count               = 2'd1;
            end
            pend_width_next = '0;
            bytes_rem_next  = '0;
            partial_next    = '0;
            halted_next     = 1'b0;
            count_clear     = 1'b1;
        end else if (halted_reg) begin
            // bytes ignored until terminator
        end else if (pend_width_reg == 3'd0) begin
            if (lead_emit) begin
                batch.slot0 = lead_res;
                batch.count = 2'd1;
                ok_hit      = lead_ok;
                if (!lead_ok && error_policy) begin
                    halted_next = 1'b1;
                end
            end else begin
                pend_width_next = lead.width;
                bytes_rem_next  = lead.width[1:0] - 2'd1;
                partial_next    = lead.bits;
            end
        end else if (data_byte[7:6] != 2'b10) begin
            // bad continuation, then retry byte as lead in skip mode
            batch.slot0.seq_width = taken;
            batch.slot0.status    = ST_BAD_CONT;
            batch.count           = 2'd1;
            pend_width_next       = '0;
            bytes_rem_next        = '0;
            partial_next          = '0;
            if (error_policy) begin
                halted_next = 1'b1;
            end else if (lead_emit) begin
                batch.slot1 = lead_res;
                batch.count = 2'd2;
                ok_hit      = lead_ok;
            end else begin
                pend_width_next = lead.width;
                bytes_rem_next  = lead.width[1:0] - 2'd1;
                partial_next    = lead.bits;
            end
        end else begin
            partial_next   = cont_cp;
            bytes_rem_next = rem_dec;
            if (rem_dec == 2'd0) begin
                batch.slot0.codepoint = (fin_status == ST_OK) ? cont_cp : 21'd0;
                batch.slot0.seq_width = pend_width_reg;
                batch.slot0.status    = fin_status;
                batch.count           = 2'd1;
                ok_hit                = (fin_status == ST_OK);
                pend_width_next       = '0;
                bytes_rem_next        = '0;
                partial_next          = '0;
                if (fin_status != ST_OK && error_policy) begin
                    halted_next = 1'b1;
                end
            end
        end
        if (!accept) begin
            batch.count = 2'd0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_width_reg  <= '0;
            bytes_rem_reg   <= '0;
            partial_reg     <= '0;
            valid_count_reg <= '0;
            halted_reg      <= 1'b0;
        end else if (accept) begin
            pend_width_reg <= pend_width_next;
            bytes_rem_reg  <= bytes_rem_next;
            partial_reg    <= partial_next;
            halted_reg     <= halted_next;
            if (count_clear) begin
                valid_count_reg <= '0;
            end else if (ok_hit && valid_count_reg != INDEX_MAX) begin
                valid_count_reg <= valid_count_reg + 32'd1;
            end
        end
    end

endmodule

/* src/utf8sv_outq.sv */
// ============================================================================
// utf8sv_outq
// Four-entry result queue taking up to two results a cycle; class flags
// are derived from the head entry.
// ============================================================================
module utf8sv_outq
    import utf8sv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  batch_t      batch,
    output logic        room,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_codepoint,
    output logic [2:0]  m_seq_width,
    output logic [2:0]  m_status,
    output logic [31:0] m_cp_index,
    output logic        m_is_printable,
    output logic        m_is_digit,
    output logic        m_is_alpha,
    output logic        m_is_upper,
    output logic        m_is_lower,
    output logic        m_is_space,
    output logic        m_is_punct,
    output logic        m_end_of_text
);

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] fill_reg;
    logic       pop;
    result_t    head;
    logic       ok;
    logic [20:0] c;
    logic       up, lo;

    assign room    = (fill_reg <= 3'd2);
    assign m_valid = (fill_reg != 3'd0);
    assign pop     = m_valid && m_ready;

    // Storage and pointers
    always_ff @(posedge aclk) begin
        if (batch.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= batch.slot0;
        end
        if (batch.count == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= batch.slot1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + batch.count;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            fill_reg <= fill_reg + {1'b0, batch.count} - {2'b00, pop};
        end
    end

    // Head fields and character classes
    always_comb begin
        head = entry_reg[rd_ptr_reg];
        ok   = (head.status == ST_OK) && !head.end_of_text;
        c    = head.codepoint;
        up   = ok && c >= 21'h41 && c <= 21'h5A;
        lo   = ok && c >= 21'h61 && c <= 21'h7A;
        m_codepoint    = c;
        m_seq_width    = head.seq_width;
        m_status       = head.status;
        m_cp_index     = head.cp_index;
        m_end_of_text  = head.end_of_text;
        m_is_printable = ok && c >= 21'h20 && c <= 21'h3FF && !(c >= 21'h80 && c <= 21'h9F);
        m_is_digit     = ok && c >= 21'h30 && c <= 21'h39;
        m_is_alpha     = up || lo;
        m_is_upper     = up;
        m_is_lower     = lo;
        m_is_space     = ok && (c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D);
        m_is_punct     = ok && ((c >= 21'h21 && c <= 21'h2F) || (c >= 21'h3A && c <= 21'h3F) ||
                                (c >= 21'h5B && c <= 21'h5D) || c == 21'h5F ||
                                (c >= 21'h7B && c <= 21'h7E));
    end

endmodule

/* src/utf8_stream_decoder_validator.sv */
// ============================================================================
// utf8_stream_decoder_validator
// UTF-8 byte stream decoder with validation, error policy and class flags.
//
//   channel   direction  payload                         handshake
//   s_        in         data_byte (8)                   s_valid / s_ready
//   m_        out        codepoint, width, status,       m_valid / m_ready
//                        index, class flags, end flag
//   APB       in/out     error_policy at 0x0             psel/penable/pready
//
// One byte per cycle is taken while the result queue has room for two
// entries; the decode of a byte is combinational and its results are
// written into the queue that drives m_. A byte that gives two results
// (terminator after an open sequence, bad continuation retried as a lead)
// occupies two queue entries. Reset is synchronous and clears the sequence
// state, index and queue. A stalled m_ready backs up the four-entry queue;
// s_ready drops once three entries are held.
// ============================================================================
module utf8_stream_decoder_validator
    import utf8sv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // byte input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [20:0]           m_codepoint,
    output logic [2:0]            m_seq_width,
    output logic [2:0]            m_status,
    output logic [31:0]           m_cp_index,
    output logic                  m_is_printable,
    output logic                  m_is_digit,
    output logic                  m_is_alpha,
    output logic                  m_is_upper,
    output logic                  m_is_lower,
    output logic                  m_is_space,
    output logic                  m_is_punct,
    output logic                  m_end_of_text,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic   policy_reg;
    logic   room;
    logic   accept;
    batch_t batch;

    assign pready  = 1'b1;
    assign s_ready = room;
    assign accept  = s_valid && room;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_POLICY) begin
            policy_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_POLICY) ? {31'd0, policy_reg} : 32'd0;

    utf8sv_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .data_byte    (s_data_byte),
        .error_policy (policy_reg),
        .batch        (batch)
    );

    utf8sv_outq u_outq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .batch          (batch),
        .room           (room),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_codepoint    (m_codepoint),
        .m_seq_width    (m_seq_width),
        .m_status       (m_status),
        .m_cp_index     (m_cp_index),
        .m_is_printable (m_is_printable),
        .m_is_digit     (m_is_digit),
        .m_is_alpha     (m_is_alpha),
        .m_is_upper     (m_is_upper),
        .m_is_lower     (m_is_lower),
        .m_is_space     (m_is_space),
        .m_is_punct     (m_is_punct),
        .m_end_of_text  (m_end_of_text)
    );

endmodule
